@@ hdl/miller_rabin_round_core_assert.svh @@
// Assertion macros for the Miller-Rabin round core checker.
`ifndef MILLER_RABIN_ROUND_CORE_ASSERT_SVH
`define MILLER_RABIN_ROUND_CORE_ASSERT_SVH
// Implication checked on every clock edge, disabled in reset.
`define MR_ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define MR_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

@@ hdl/mrr_pkg.sv @@
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared types and constants for the Miller-Rabin round core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mrr_pkg;
  localparam int FieldWidth = 62;

  typedef struct packed {
    logic [FieldWidth-1:0] candidate;
    logic [FieldWidth-1:0] witness;
  } req_t;

  typedef struct packed {
    logic probable_prime;
  } rsp_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_REDUCE = 8'b00000010,
    ST_SPLIT  = 8'b00000100,
    ST_POWBIT = 8'b00001000,
    ST_MUL    = 8'b00010000,
    ST_CHECK  = 8'b00100000,
    ST_SQLOOP = 8'b01000000,
    ST_OUT    = 8'b10000000
  } state_t;

  typedef enum logic [1:0] {
    MUL_RB = 2'd0,
    MUL_BB = 2'd1,
    MUL_SQ = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     red_step;
    logic     red_commit;
    logic     split_step;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     exp_shift;
    logic     copy_rb;
    logic     k_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic n_small;
    logic n_two;
    logic red_done;
    logic m_odd;
    logic mul_busy;
    logic exp_zero;
    logic r_one;
    logic b_nm1;
    logic k_zero;
  } dp_status_t;
endpackage

@@ hdl/mrr_stream_if.sv @@
// ----------------------------------------------------------------------------
// mrr_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mrr_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/miller_rabin_round_core.sv @@
// Miller-Rabin round core: one verdict per accepted transaction.
// Steps: reduce the witness modulo the candidate, then up to two modular products
// per exponent bit (r*b, b*b), then one squaring per k-loop iteration.
// One shift-add modular multiplier, one bit per cycle, is shared by all products.
// One transaction at a time; a new one is taken once the verdict is collected.
// Synchronous active-high reset returns the controller to idle.
// ----------------------------------------------------------------------------
// miller_rabin_round_core
// Top level joining the controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module miller_rabin_round_core #(
  parameter int NUM_WIDTH = 62
) (
  input logic  clk,
  input logic  rst,
  mrr_stream_if.sink   in_chan,
  mrr_stream_if.source out_chan
);
  mrr_pkg::dp_cmd_t    cmd;
  mrr_pkg::dp_status_t status;
  logic                verdict;

  mrr_controller u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_chan.valid), .in_ready(in_chan.ready),
    .out_valid(out_chan.valid), .out_ready(out_chan.ready),
    .verdict(verdict), .cmd(cmd), .status(status)
  );

  mrr_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
    .clk(clk), .rst(rst),
    .candidate(in_chan.data.candidate[NUM_WIDTH-1:0]),
    .witness(in_chan.data.witness[NUM_WIDTH-1:0]),
    .cmd(cmd), .status(status)
  );

  assign out_chan.data.probable_prime = verdict;
endmodule

@@ hdl/mrr_datapath.sv @@
// ----------------------------------------------------------------------------
// mrr_datapath
// Registers, modular shift-add multiplier, restoring reducer and k counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mrr_datapath #(
  parameter int NUM_WIDTH = 62
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [NUM_WIDTH-1:0]   candidate,
  input  logic [NUM_WIDTH-1:0]   witness,
  input  mrr_pkg::dp_cmd_t       cmd,
  output mrr_pkg::dp_status_t    status
);
  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0] n, nm1, m, r, b, red_q;
  logic [NUM_WIDTH:0]   red_rem;
  logic [CW-1:0]        red_cnt, k;
  logic [NUM_WIDTH-1:0] acc, p, y;
  logic                 mbusy, mlast;
  mrr_pkg::mul_sel_t    msel;

  logic [NUM_WIDTH:0]   rem_sh, rem_n, acc_s, p_s;
  logic [NUM_WIDTH-1:0] acc_n, p_n;

  always_comb begin
    rem_sh = {red_rem[NUM_WIDTH-1:0], red_q[NUM_WIDTH-1]};
    rem_n  = (rem_sh >= {1'b0, n}) ? rem_sh - {1'b0, n} : rem_sh;
    acc_s  = {1'b0, acc} + {1'b0, p};
    acc_n  = (acc_s >= {1'b0, n}) ? NUM_WIDTH'(acc_s - {1'b0, n}) : acc_s[NUM_WIDTH-1:0];
    p_s    = {p, 1'b0};
    p_n    = (p_s >= {1'b0, n}) ? NUM_WIDTH'(p_s - {1'b0, n}) : p_s[NUM_WIDTH-1:0];
    mlast  = (y[NUM_WIDTH-1:1] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
    end else if (cmd.mul_start) begin
      mbusy <= 1'b1;
    end else if (mbusy && mlast) begin
      mbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n       <= candidate;
      nm1     <= candidate - NUM_WIDTH'(1);
      m       <= candidate - NUM_WIDTH'(1);
      red_q   <= witness;
      red_rem <= '0;
      red_cnt <= '0;
      k       <= '0;
      r       <= NUM_WIDTH'(1);
    end else if (cmd.red_step) begin
      red_q   <= {red_q[NUM_WIDTH-2:0], 1'b0};
      red_rem <= rem_n;
      red_cnt <= red_cnt + CW'(1);
    end else if (cmd.red_commit) begin
      b <= red_rem[NUM_WIDTH-1:0];
    end else if (cmd.split_step) begin
      m <= m >> 1;
      k <= k + CW'(1);
    end else if (cmd.exp_shift) begin
      m <= m >> 1;
    end else if (cmd.copy_rb) begin
      b <= r;
    end else if (cmd.mul_start) begin
      msel <= cmd.mul_sel;
      acc  <= '0;
      p    <= b;
      y    <= (cmd.mul_sel == mrr_pkg::MUL_RB) ? r : b;
      if (cmd.k_dec) k <= k - CW'(1);
    end else if (mbusy) begin
      if (y[0]) acc <= acc_n;
      p <= p_n;
      y <= y >> 1;
      if (mlast) begin
        if (msel == mrr_pkg::MUL_RB) r <= y[0] ? acc_n : acc;
        else b <= y[0] ? acc_n : acc;
      end
    end
  end

  always_comb begin
    status.n_small  = (n < NUM_WIDTH'(2));
    status.n_two    = (n == NUM_WIDTH'(2));
    status.red_done = (red_cnt == CW'(NUM_WIDTH));
    status.m_odd    = m[0];
    status.mul_busy = mbusy;
    status.exp_zero = (m == '0);
    status.r_one    = (r == NUM_WIDTH'(1));
    status.b_nm1    = (b == nm1);
    status.k_zero   = (k == '0);
  end
endmodule

@@ hdl/mrr_controller.sv @@
// ----------------------------------------------------------------------------
// mrr_controller
// Sequences reduction, exponent split, square-and-multiply and the k loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mrr_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                verdict,
  output mrr_pkg::dp_cmd_t    cmd,
  input  mrr_pkg::dp_status_t status
);
  mrr_pkg::state_t state, state_next;
  logic            verdict_next, phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mrr_pkg::ST_IDLE;
      verdict <= 1'b0;
      phase   <= 1'b0;
    end else begin
      state   <= state_next;
      verdict <= verdict_next;
      phase   <= phase_next;
    end
  end

  assign in_ready  = (state == mrr_pkg::ST_IDLE);
  assign out_valid = (state == mrr_pkg::ST_OUT);

  // phase: in ST_MUL, 0 = r*b running, b*b still to do; 1 = b*b running.
  always_comb begin
    state_next   = state;
    verdict_next = verdict;
    phase_next   = phase;
    cmd          = '0;
    cmd.mul_sel  = mrr_pkg::MUL_RB;
    case (state)
      mrr_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mrr_pkg::ST_REDUCE;
        end
      end
      mrr_pkg::ST_REDUCE: begin
        if (status.n_small) begin
          verdict_next = 1'b0;
          state_next   = mrr_pkg::ST_OUT;
        end else if (status.n_two) begin
          verdict_next = 1'b1;
          state_next   = mrr_pkg::ST_OUT;
        end else if (status.red_done) begin
          cmd.red_commit = 1'b1;
          state_next     = mrr_pkg::ST_SPLIT;
        end else begin
          cmd.red_step = 1'b1;
        end
      end
      mrr_pkg::ST_SPLIT: begin
        if (status.m_odd) state_next = mrr_pkg::ST_POWBIT;
        else cmd.split_step = 1'b1;
      end
      mrr_pkg::ST_POWBIT: begin
        if (status.exp_zero) begin
          state_next = mrr_pkg::ST_CHECK;
        end else begin
          cmd.mul_start = 1'b1;
          if (status.m_odd) begin
            cmd.mul_sel = mrr_pkg::MUL_RB;
            phase_next  = 1'b0;
          end else begin
            cmd.mul_sel = mrr_pkg::MUL_BB;
            phase_next  = 1'b1;
          end
          state_next = mrr_pkg::ST_MUL;
        end
      end
      mrr_pkg::ST_MUL: begin
        if (!status.mul_busy) begin
          if (!phase) begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = mrr_pkg::MUL_BB;
            phase_next    = 1'b1;
          end else begin
            cmd.exp_shift = 1'b1;
            state_next    = mrr_pkg::ST_POWBIT;
          end
        end
      end
      mrr_pkg::ST_CHECK: begin
        if (status.r_one) begin
          verdict_next = 1'b1;
          state_next   = mrr_pkg::ST_OUT;
        end else begin
          cmd.copy_rb = 1'b1;
          state_next  = mrr_pkg::ST_SQLOOP;
        end
      end
      mrr_pkg::ST_SQLOOP: begin
        if (!status.mul_busy) begin
          if (status.k_zero) begin
            verdict_next = 1'b0;
            state_next   = mrr_pkg::ST_OUT;
          end else if (status.b_nm1) begin
            verdict_next = 1'b1;
            state_next   = mrr_pkg::ST_OUT;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = mrr_pkg::MUL_SQ;
            cmd.k_dec     = 1'b1;
          end
        end
      end
      mrr_pkg::ST_OUT: begin
        if (out_ready) state_next = mrr_pkg::ST_IDLE;
      end
      default: state_next = mrr_pkg::ST_IDLE;
    endcase
  end
endmodule

@@ hdl/mrr_checker.sv @@
// ----------------------------------------------------------------------------
// mrr_checker
// Port-level checks on the Miller-Rabin round core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "miller_rabin_round_core_assert.svh"
module mrr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic verdict
);
  `MR_ASSERT_IMPL(a_excl, clk, rst, out_valid, !in_ready, "ready while result pending")
  `MR_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready && !out_valid, "busy expected")
  `MR_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(verdict), "result dropped")
  `MR_ASSERT_NEXT(a_idle, clk, rst, out_valid && out_ready, in_ready, "not idle after transaction")
endmodule

bind miller_rabin_round_core mrr_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_chan.valid), .in_ready(in_chan.ready),
  .out_valid(out_chan.valid), .out_ready(out_chan.ready),
  .verdict(out_chan.data.probable_prime)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Miller-Rabin round core: drives candidate and
// witness pairs, predicts each round verdict and compares it in order.
// ----------------------------------------------------------------------------
module tb;
  localparam int W = 62;
  localparam longint unsigned CYCLE_LIMIT = 5000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int errors = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  longint unsigned cycles = 0;
  logic verdicts_due[$];

  mrr_stream_if #(.payload_t(mrr_pkg::req_t)) in_chan ();
  mrr_stream_if #(.payload_t(mrr_pkg::rsp_t)) out_chan ();

  miller_rabin_round_core #(.NUM_WIDTH(W)) DUT (
    .clk(clk),
    .rst(rst),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    out_chan.ready = 1'b0;
  end

  function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] n);
    logic [63:0] acc, p, s;
    acc = 0;
    p = x % n;
    while (y != 0) begin
      if (y[0]) begin
        s = acc + p;
        acc = (s >= n) ? s - n : s;
      end
      s = p + p;
      p = (s >= n) ? s - n : s;
      y = y >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e, logic [63:0] n);
    logic [63:0] r;
    r = 1;
    b = b % n;
    while (e != 0) begin
      if (e[0]) r = mod_mul(b, r, n);
      b = mod_mul(b, b, n);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic round_verdict(logic [W-1:0] cand, logic [W-1:0] wit);
    logic [63:0] n, m, b, k, i;
    n = 64'(cand);
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    m = n - 1;
    k = 0;
    while (!m[0]) begin
      m = m >> 1;
      k++;
    end
    b = mod_pow(64'(wit) % n, m, n);
    if (b == 1) return 1'b1;
    for (i = 0; i < k; i++) begin
      if (b == n - 1) return 1'b1;
      b = mod_mul(b, b, n);
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_chan.valid && out_chan.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("probable_prime: unexpected transaction, actual %0b",
               out_chan.data.probable_prime);
        errors++;
      end else begin
        if (out_chan.data.probable_prime !== verdicts_due[0]) begin
          $error("probable_prime: expected %0b actual %0b", verdicts_due[0],
                 out_chan.data.probable_prime);
          errors++;
        end
        void'(verdicts_due.pop_front());
      end
    end
  end

  task automatic send_round(logic [W-1:0] cand, logic [W-1:0] wit);
    while ($urandom_range(99) < tx_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= '{candidate: cand, witness: wit};
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    verdicts_due = {verdicts_due, round_verdict(cand, wit)};
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [W-1:0] rand_field();
    return W'({$urandom(), $urandom()});
  endfunction

  task automatic test_special_cases();
    send_round(0, 5);
    send_round(1, 1);
    send_round(2, 1);
    send_round(2, 7);
    send_round(3, 2);
    send_round(9, 9);
    send_round(15, 0);
    send_round(13, 14);
    send_round(12, 5);
    send_round(4, 3);
    send_round(561, 2);
    send_round(561, 50);
    send_round(41041, 3);
    drain();
  endtask

  task automatic test_extremes();
    send_round('1, '1);
    send_round('1, 2);
    send_round(62'd4611686018427387847, '1);
    send_round(62'd4611686018427387847, 62'd4611686018427387846);
    send_round(62'd2305843009213693951, 3);
    send_round(62'd2305843009213693951, '1);
    send_round(62'd1000000007, 62'd123456789);
    send_round({1'b1, 61'd0}, 3);
    send_round(3, '1);
    drain();
  endtask

  task automatic test_random(int n_items);
    logic [W-1:0] cand, wit;
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(4))
        0: cand = rand_field() | W'(1);
        1: cand = rand_field();
        2: cand = W'($urandom_range(2000));
        3: cand = (rand_field() >> $urandom_range(60)) | W'(1);
        default: begin
          case ($urandom_range(3))
            0: cand = 62'd4611686018427387847;
            1: cand = 62'd2305843009213693951;
            2: cand = 62'd1000000007;
            default: cand = 62'd41041;
          endcase
        end
      endcase
      wit = $urandom_range(1) ? rand_field() : rand_field() >> $urandom_range(61);
      send_round(cand, wit);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle = 37;
    rx_idle = 86;
    test_special_cases();
    test_extremes();
    test_random(26);
    drain();
    tx_idle = 86;
    rx_idle = 37;
    test_random(26);
    tx_idle = 0;
    rx_idle = 0;
    test_random(26);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/mrr_pkg.sv
hdl/mrr_stream_if.sv
hdl/mrr_datapath.sv
hdl/mrr_controller.sv
hdl/miller_rabin_round_core.sv
hdl/mrr_checker.sv
sim/tb.sv
